FILE: src/fqs_pkg.sv
// shared definitions for the fifo queue with search block
// operation codes, status codes and the result record; no dependencies
package fqs_pkg;

  // operation codes carried in the input tuser
  localparam logic [1:0] MODE_ENQ  = 2'd0;
  localparam logic [1:0] MODE_DEQ  = 2'd1;
  localparam logic [1:0] MODE_SRCH = 2'd2;

  // status codes carried in the output tuser
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_EMPTY    = 2'd1;
  localparam logic [1:0] STAT_FULL     = 2'd2;
  localparam logic [1:0] STAT_NOTFOUND = 2'd3;

  // fixed field widths of the result item
  localparam int unsigned REM_W = 32;
  localparam int unsigned POS_W = 6;
  localparam int unsigned OCC_W = 5;

  typedef struct packed {
    logic [1:0]             status;
    logic [REM_W-1:0]       removed_value;
    logic [POS_W-1:0]       position;
    logic [OCC_W-1:0]       occupancy;
  } res_t;

endpackage

FILE: src/fqs_store.sv
// ring entry store of the fifo queue with search block
// one write port and one read port with registered read data; no dependencies
module fqs_store #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned DW    = 32,
  parameter int unsigned AW    = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/fifo_queue_with_search.sv
// top level of the fifo queue with search block
// sequencer, ring pointers and output register; uses fqs_pkg and fqs_store
//
// usage
//   input channel in_*: one item is an operation; in_tuser selects it
//   (enqueue, dequeue, search) and in_tdata carries the value or search key.
//   output channel out_*: exactly one result item per input item, in order;
//   out_tuser is the status, out_tdata holds removed value, position and
//   occupancy after the operation.
// timing
//   in_tready is high only while the sequencer is idle, one item at a time.
//   enqueue: the result goes from the pending register to the output register.
//   dequeue: passes through S_DEQ for the registered read of the store.
//   search: compares at most DEPTH entries and stops at the first hit; one
//   comparator walks the store one entry a cycle from the head,
//   fed by the single read port.
// reset
//   rst_n low clears pointers, count, sequencer and output valid; the store
//   itself is not cleared, entries are read only after being written.
// stall
//   a finished result waits in the output register; the sequencer holds the
//   next result until that register is free, and inputs wait meanwhile.
module fifo_queue_with_search #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [1:0]  in_tuser,   // [1:0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [31:0] removed_value, [37:32] position,
                                  // [42:38] occupancy, [47:43] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  import fqs_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  // value width wide enough for both the port field and a stored entry
  localparam int unsigned XW = (DATA_WIDTH > REM_W) ? DATA_WIDTH : REM_W;

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DEQ  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]            state_r, state_nxt;
  logic [AW-1:0]         head_r, head_nxt;
  logic [AW-1:0]         tail_r, tail_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [AW-1:0]         scan_addr_r, scan_addr_nxt;
  logic [AW-1:0]         scan_i_r, scan_i_nxt;
  logic [DATA_WIDTH-1:0] key_r, key_nxt;
  res_t                  pend_r, pend_nxt;
  res_t                  res_r, res_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic                  in_acc;
  logic [1:0]            in_mode;
  logic signed [31:0]    in_value;
  logic signed [XW-1:0]  in_value_ext;
  logic [DATA_WIDTH-1:0] in_key;

  logic                  wr_en;
  logic [AW-1:0]         rd_addr;
  logic [DATA_WIDTH-1:0] rd_data;
  logic signed [DATA_WIDTH-1:0] rd_data_s;
  logic signed [XW-1:0]  rd_data_ext;

  logic                  hit;
  logic [CW-1:0]         scan_i_inc;
  logic [AW+6:0]         pos_w;
  logic [CW+5:0]         occ_now_w;
  logic [CW+5:0]         occ_inc_w;
  logic [CW+5:0]         occ_dec_w;

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] a);
    next_slot = (a == AW'(DEPTH - 1)) ? '0 : a + AW'(1);
  endfunction

  assign in_mode      = in_tuser;
  assign in_value     = in_tdata;
  assign in_value_ext = XW'(in_value);
  assign in_key       = in_value_ext[DATA_WIDTH-1:0];
  assign in_tready    = (state_r == S_IDLE);
  assign in_acc       = in_tvalid && in_tready;

  // store: write at tail on an accepted enqueue with room
  assign wr_en   = in_acc && (in_mode == MODE_ENQ) && (count_r != CW'(DEPTH));
  // read port follows the head, or the entry after the one under compare
  assign rd_addr = (state_r == S_SCAN) ? next_slot(scan_addr_r) : head_r;

  fqs_store #(
    .DEPTH (DEPTH),
    .DW    (DATA_WIDTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail_r),
    .wr_data (in_key),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // removed value sign-extended or truncated to the port width
  assign rd_data_s   = rd_data;
  assign rd_data_ext = XW'(rd_data_s);

  // shared comparator and scan bookkeeping
  assign hit        = (rd_data == key_r);
  assign scan_i_inc = CW'(scan_i_r) + CW'(1);
  assign pos_w      = (AW + 7)'(scan_i_r) + (AW + 7)'(1);

  // occupancy fields masked to the port width
  assign occ_now_w = (CW + 6)'(count_r);
  assign occ_inc_w = (CW + 6)'(count_r) + (CW + 6)'(1);
  assign occ_dec_w = (CW + 6)'(count_r) - (CW + 6)'(1);

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    scan_addr_nxt = scan_addr_r;
    scan_i_nxt    = scan_i_r;
    key_nxt       = key_r;
    pend_nxt      = pend_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          pend_nxt.status        = STAT_OK;
          pend_nxt.removed_value = '0;
          pend_nxt.position      = '0;
          pend_nxt.occupancy     = occ_now_w[OCC_W-1:0];
          state_nxt              = S_DONE;
          unique case (in_mode)
            MODE_ENQ: begin
              if (count_r == CW'(DEPTH)) begin
                pend_nxt.status = STAT_FULL;
              end else begin
                tail_nxt           = next_slot(tail_r);
                count_nxt          = count_r + CW'(1);
                pend_nxt.occupancy = occ_inc_w[OCC_W-1:0];
              end
            end
            MODE_DEQ: begin
              if (count_r == '0) begin
                pend_nxt.status = STAT_EMPTY;
              end else begin
                state_nxt = S_DEQ;
              end
            end
            MODE_SRCH: begin
              key_nxt       = in_key;
              scan_addr_nxt = head_r;
              scan_i_nxt    = '0;
              if (count_r == '0) begin
                pend_nxt.status   = STAT_NOTFOUND;
                pend_nxt.position = '1;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            default: begin
              // no operation, occupancy only
            end
          endcase
        end
      end
      S_DEQ: begin
        pend_nxt.removed_value = rd_data_ext[REM_W-1:0];
        pend_nxt.occupancy     = occ_dec_w[OCC_W-1:0];
        head_nxt               = next_slot(head_r);
        count_nxt              = count_r - CW'(1);
        state_nxt              = S_DONE;
      end
      S_SCAN: begin
        if (hit) begin
          pend_nxt.position = pos_w[POS_W-1:0];
          state_nxt         = S_DONE;
        end else if (scan_i_inc >= count_r) begin
          pend_nxt.status   = STAT_NOTFOUND;
          pend_nxt.position = '1;
          state_nxt         = S_DONE;
        end else begin
          scan_i_nxt    = scan_i_r + AW'(1);
          scan_addr_nxt = next_slot(scan_addr_r);
        end
      end
      S_DONE: begin
        // hand the result over once the output register is free
        if (!out_valid_r || out_tready) begin
          res_nxt       = pend_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    scan_addr_r <= scan_addr_nxt;
    scan_i_r    <= scan_i_nxt;
    key_r       <= key_nxt;
    pend_r      <= pend_nxt;
    res_r       <= res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.status;
  assign out_tdata  = {5'd0, res_r.occupancy, res_r.position, res_r.removed_value};

endmodule
